// ----- rtl/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// Character LCD terminal package
// Character codes, control word layout and microprogram of the sequencer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int PcW = 5;

  localparam logic [7:0] ChrNewline   = 8'h0A;
  localparam logic [7:0] ChrBackspace = 8'h08;
  localparam logic [7:0] ChrBell      = 8'h07;
  localparam logic [7:0] ChrFormFeed  = 8'h0C;
  localparam logic [7:0] ChrTab       = 8'h09;

  localparam logic [7:0] LcdClear   = 8'h01;
  localparam logic [7:0] LcdSetAddr = 8'h80;
  localparam logic [7:0] LcdSpace   = 8'h20;

  localparam logic [4:0] TabStepReset = 5'd4;

  // program addresses
  localparam logic [PcW-1:0] PcIdle      = 5'd0;
  localparam logic [PcW-1:0] PcNewline   = 5'd1;
  localparam logic [PcW-1:0] PcNlSpace   = 5'd3;
  localparam logic [PcW-1:0] PcPrint     = 5'd5;
  localparam logic [PcW-1:0] PcPrSpace   = 5'd8;
  localparam logic [PcW-1:0] PcPrChar    = 5'd10;
  localparam logic [PcW-1:0] PcBackspace = 5'd11;
  localparam logic [PcW-1:0] PcFormFeed  = 5'd13;
  localparam logic [PcW-1:0] PcTab       = 5'd14;
  localparam logic [PcW-1:0] PcTabLoop   = 5'd15;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ADDR,
    EM_SPACE,
    EM_CHAR,
    EM_CLEAR
  } emit_e;

  typedef enum logic [2:0] {
    COL_KEEP,
    COL_ZERO,
    COL_DEC,
    COL_INC,
    COL_TAB
  } col_op_e;

  typedef enum logic [1:0] {
    ROW_KEEP,
    ROW_ZERO,
    ROW_NEXT,
    ROW_TAB
  } row_op_e;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_CLEAR,
    CNT_INC,
    CNT_STEP
  } cnt_op_e;

  typedef enum logic [1:0] {
    BR_NONE,
    BR_CNT_LT,
    BR_COL_LT,
    BR_CNT_LE
  } br_e;

  typedef struct packed {
    emit_e          emit;
    logic           last;
    col_op_e        col;
    row_op_e        row;
    cnt_op_e        cnt;
    br_e            br;
    logic [PcW-1:0] target;
    logic           done;
  } uword_t;

  localparam uword_t UwNop =
    '{EM_NONE, 1'b0, COL_KEEP, ROW_KEEP, CNT_KEEP, BR_NONE, PcIdle, 1'b0};

  function automatic uword_t uw(emit_e em, logic lst, col_op_e co, row_op_e ro,
                                cnt_op_e cn, br_e b, logic [PcW-1:0] tgt,
                                logic dn);
    uword_t w;
    w.emit   = em;
    w.last   = lst;
    w.col    = co;
    w.row    = ro;
    w.cnt    = cn;
    w.br     = b;
    w.target = tgt;
    w.done   = dn;
    return w;
  endfunction

  function automatic uword_t rom(logic [PcW-1:0] pc);
    uword_t w;
    w = UwNop;
    unique case (pc)
      5'd1:  w = uw(EM_NONE,  1'b0, COL_ZERO, ROW_NEXT, CNT_CLEAR, BR_NONE, PcIdle, 1'b0);
      5'd2:  w = uw(EM_ADDR,  1'b0, COL_KEEP, ROW_KEEP, CNT_KEEP, BR_NONE, PcIdle, 1'b0);
      5'd3:  w = uw(EM_SPACE, 1'b0, COL_KEEP, ROW_KEEP, CNT_INC, BR_CNT_LT, PcNlSpace, 1'b0);
      5'd4:  w = uw(EM_ADDR,  1'b1, COL_KEEP, ROW_KEEP, CNT_KEEP, BR_NONE, PcIdle, 1'b1);
      5'd5:  w = uw(EM_NONE,  1'b0, COL_KEEP, ROW_KEEP, CNT_KEEP, BR_COL_LT, PcPrChar, 1'b0);
      5'd6:  w = uw(EM_NONE,  1'b0, COL_ZERO, ROW_NEXT, CNT_CLEAR, BR_NONE, PcIdle, 1'b0);
      5'd7:  w = uw(EM_ADDR,  1'b0, COL_KEEP, ROW_KEEP, CNT_KEEP, BR_NONE, PcIdle, 1'b0);
      5'd8:  w = uw(EM_SPACE, 1'b0, COL_KEEP, ROW_KEEP, CNT_INC, BR_CNT_LT, PcPrSpace, 1'b0);
      5'd9:  w = uw(EM_ADDR,  1'b0, COL_KEEP, ROW_KEEP, CNT_KEEP, BR_NONE, PcIdle, 1'b0);
      5'd10: w = uw(EM_CHAR,  1'b1, COL_INC,  ROW_KEEP, CNT_KEEP, BR_NONE, PcIdle, 1'b1);
      5'd11: w = uw(EM_NONE,  1'b0, COL_DEC,  ROW_KEEP, CNT_KEEP, BR_NONE, PcIdle, 1'b0);
      5'd12: w = uw(EM_ADDR,  1'b1, COL_KEEP, ROW_KEEP, CNT_KEEP, BR_NONE, PcIdle, 1'b1);
      5'd13: w = uw(EM_CLEAR, 1'b1, COL_ZERO, ROW_ZERO, CNT_KEEP, BR_NONE, PcIdle, 1'b1);
      5'd14: w = uw(EM_NONE,  1'b0, COL_KEEP, ROW_KEEP, CNT_STEP, BR_NONE, PcIdle, 1'b0);
      5'd15: w = uw(EM_NONE,  1'b0, COL_KEEP, ROW_KEEP, CNT_STEP, BR_CNT_LE, PcTabLoop, 1'b0);
      5'd16: w = uw(EM_NONE,  1'b0, COL_TAB,  ROW_TAB,  CNT_KEEP, BR_NONE, PcIdle, 1'b0);
      5'd17: w = uw(EM_ADDR,  1'b1, COL_KEEP, ROW_KEEP, CNT_KEEP, BR_NONE, PcIdle, 1'b1);
      default: w = UwNop;
    endcase
    return w;
  endfunction

  function automatic logic [PcW-1:0] dispatch(logic [7:0] chr);
    logic [PcW-1:0] pc;
    unique case (chr)
      ChrNewline:   pc = PcNewline;
      ChrBackspace: pc = PcBackspace;
      ChrBell:      pc = PcIdle;
      ChrFormFeed:  pc = PcFormFeed;
      ChrTab:       pc = PcTab;
      default:      pc = PcPrint;
    endcase
    return pc;
  endfunction

  function automatic logic [6:0] row_offset(logic [1:0] row);
    logic [6:0] off;
    unique case (row)
      2'd0: off = 7'h00;
      2'd1: off = 7'h40;
      2'd2: off = 7'h14;
      2'd3: off = 7'h54;
      default: off = 7'h00;
    endcase
    return off;
  endfunction

endpackage

// ----- rtl/char_lcd_terminal_controller.sv -----
// ----------------------------------------------------------------------------
// Character LCD terminal controller
// Turns character codes into command and data bytes for a character LCD.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character code per item. m_axis carries the LCD bytes
//   it causes: tdata is the byte, tuser is high for a data byte and low for a
//   command, tlast marks the final byte of the character. A bell causes none.
//   cfg_we_i/cfg_data_i write the tab step while the block is idle.
// Timing:
//   A microprogram runs one control word per cycle while no stall holds it;
//   each emitted byte comes from one control word. The row blanking runs a
//   space loop and the tab runs a tab stop search loop.
//   s_axis_tready is high only while the sequencer sits idle.
// Reset:
//   Cursor at column 0, row 0, tab step 4, no byte pending.
// Stall:
//   The byte register holds while m_axis_tready is low, and the sequencer
//   stops at its next emitting step until the register drains.
// ----------------------------------------------------------------------------
module char_lcd_terminal_controller #(
  parameter int COLUMNS = 20,
  parameter int ROWS    = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_data_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] lcd_byte
  output logic       m_axis_tuser,   // [0] is_data
  output logic       m_axis_tlast
);

  localparam int CW = $clog2(COLUMNS + 1);
  localparam int AW = ((CW > 5) ? CW : 5) + 1;
  localparam logic [AW-1:0] CntCols = AW'(COLUMNS);
  localparam logic [AW-1:0] CntLast = AW'(COLUMNS - 1);
  localparam logic [2:0]    RowsW   = 3'(ROWS);

  logic [clt_pkg::PcW-1:0] pc_q, pc_d;
  logic [CW-1:0]           col_q, col_d;
  logic [1:0]              row_q, row_d;
  logic [AW-1:0]           cnt_q, cnt_d;
  logic [7:0]              char_q;
  logic [4:0]              tab_step_q;
  logic                    out_valid_q;
  logic [7:0]              out_byte_q;
  logic                    out_data_q;
  logic                    out_last_q;

  clt_pkg::uword_t uw;
  logic            active;
  logic            stall;
  logic            br_taken;
  logic [AW-1:0]   step_ext;
  logic [AW-1:0]   col_ext;
  logic            cnt_le;
  logic [1:0]      row_next;
  logic [6:0]      addr;
  logic [7:0]      emit_byte;
  logic            emit_data;

  assign uw       = clt_pkg::rom(pc_q);
  assign active   = (pc_q != clt_pkg::PcIdle);
  assign stall    = (uw.emit != clt_pkg::EM_NONE) && out_valid_q && !m_axis_tready;
  assign step_ext = (tab_step_q == 5'd0) ? AW'(1) : AW'(tab_step_q);
  assign col_ext  = AW'(col_q);
  assign cnt_le   = (cnt_q <= col_ext);
  assign row_next = (({1'b0, row_q} + 3'd1) >= RowsW) ? 2'd0 : row_q + 2'd1;
  assign addr     = 7'(col_q) + clt_pkg::row_offset(row_q);

  always_comb begin
    unique case (uw.br)
      clt_pkg::BR_NONE:   br_taken = 1'b0;
      clt_pkg::BR_CNT_LT: br_taken = (cnt_q != CntLast);
      clt_pkg::BR_COL_LT: br_taken = (col_q < CW'(COLUMNS));
      clt_pkg::BR_CNT_LE: br_taken = cnt_le;
      default:            br_taken = 1'b0;
    endcase
  end

  always_comb begin
    emit_byte = clt_pkg::LcdClear;
    emit_data = 1'b0;
    unique case (uw.emit)
      clt_pkg::EM_ADDR:  emit_byte = clt_pkg::LcdSetAddr | {1'b0, addr};
      clt_pkg::EM_SPACE: begin
        emit_byte = clt_pkg::LcdSpace;
        emit_data = 1'b1;
      end
      clt_pkg::EM_CHAR:  begin
        emit_byte = char_q;
        emit_data = 1'b1;
      end
      clt_pkg::EM_CLEAR: emit_byte = clt_pkg::LcdClear;
      default:           emit_byte = clt_pkg::LcdClear;
    endcase
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    cnt_d = cnt_q;
    unique case (uw.col)
      clt_pkg::COL_ZERO: col_d = '0;
      clt_pkg::COL_DEC:  col_d = (col_q == '0) ? '0 : col_q - CW'(1);
      clt_pkg::COL_INC:  col_d = col_q + CW'(1);
      clt_pkg::COL_TAB:  col_d = (cnt_q >= CntCols) ? '0 : CW'(cnt_q);
      default:           col_d = col_q;
    endcase
    unique case (uw.row)
      clt_pkg::ROW_ZERO: row_d = 2'd0;
      clt_pkg::ROW_NEXT: row_d = row_next;
      clt_pkg::ROW_TAB:  row_d = (cnt_q >= CntCols) ? row_next : row_q;
      default:           row_d = row_q;
    endcase
    unique case (uw.cnt)
      clt_pkg::CNT_CLEAR: cnt_d = '0;
      clt_pkg::CNT_INC:   cnt_d = cnt_q + AW'(1);
      clt_pkg::CNT_STEP: begin
        // load the first stop, then advance while it is not past the column
        if (pc_q == clt_pkg::PcTab) begin
          cnt_d = step_ext;
        end else if (cnt_le) begin
          cnt_d = cnt_q + step_ext;
        end
      end
      default:            cnt_d = cnt_q;
    endcase
    if (uw.done) begin
      pc_d = clt_pkg::PcIdle;
    end else if (br_taken) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + clt_pkg::PcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= clt_pkg::PcIdle;
      col_q       <= '0;
      row_q       <= 2'd0;
      tab_step_q  <= clt_pkg::TabStepReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tab_step_q <= cfg_data_i;
      end
      if (active && !stall && (uw.emit != clt_pkg::EM_NONE)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (!active) begin
        if (s_axis_tvalid) begin
          char_q <= s_axis_tdata;
          pc_q   <= clt_pkg::dispatch(s_axis_tdata);
        end
      end else if (!stall) begin
        col_q <= col_d;
        row_q <= row_d;
        cnt_q <= cnt_d;
        pc_q  <= pc_d;
        if (uw.emit != clt_pkg::EM_NONE) begin
          out_byte_q  <= emit_byte;
          out_data_q  <= emit_data;
          out_last_q  <= uw.last;
        end
      end
    end
  end

  assign s_axis_tready = !active;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, row_q} < RowsW) && (col_q <= CW'(COLUMNS)))
    else $error("cursor out of range");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active && !stall && (uw.emit != clt_pkg::EM_NONE) && uw.last) |=> s_axis_tready)
    else $error("sequencer busy after final byte");

  a_bell_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tdata == clt_pkg::ChrBell))
      |=> (s_axis_tready && (m_axis_tvalid == ($past(m_axis_tvalid) && !$past(m_axis_tready)))))
    else $error("bell caused a byte");

endmodule

// ----- tb/tb_char_lcd_terminal_controller.sv -----
// ----------------------------------------------------------------------------
// Character LCD terminal controller testbench
// Sends character codes on the input stream and checks every LCD byte on the
// output stream against a cursor model kept in the bench. Covers the control
// codes, row blanking, auto-wrap, tab stops across tab step settings, random
// stalls on both sides and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_char_lcd_terminal_controller;

  localparam int COLUMNS        = 20;
  localparam int ROWS           = 4;
  localparam int DRAIN_CYCLES   = COLUMNS + 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_STEP = 25;

  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last;
  } lcd_word_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [4:0] cfg_data_i    = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  logic [7:0] char_q [$];
  lcd_word_t  pending_lcd_q [$];
  lcd_word_t  got_word;

  logic [4:0] term_col;
  logic [1:0] term_row;
  logic [4:0] term_tab;
  bit         seq_data [0:31];
  logic [7:0] seq_byte [0:31];
  int         seq_len;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req      = 1'b0;
  int  hold_left     = 0;
  int  n_queued      = 0;
  int  n_accepted    = 0;
  int  n_bytes       = 0;
  int  n_wraps       = 0;
  int  n_err         = 0;
  int  quiet_cycles  = 0;

  logic [7:0] directed [0:23] = '{
    clt_pkg::ChrFormFeed, clt_pkg::ChrBackspace, clt_pkg::ChrBell, 8'h00, 8'hFF,
    clt_pkg::ChrNewline, clt_pkg::ChrNewline, clt_pkg::ChrNewline, clt_pkg::ChrNewline,
    clt_pkg::ChrFormFeed, clt_pkg::ChrTab, clt_pkg::ChrTab, clt_pkg::ChrTab,
    clt_pkg::ChrTab, clt_pkg::ChrTab, clt_pkg::ChrTab, clt_pkg::ChrTab,
    clt_pkg::ChrTab, clt_pkg::ChrTab,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h7E
  };
  logic [4:0] tab_plan [0:4] = '{5'd0, 5'd31, 5'd1, 5'd20, 5'd7};

  char_lcd_terminal_controller #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [6:0] row_base(input logic [1:0] r);
    case (r)
      2'd0:    return 7'h00;
      2'd1:    return 7'h40;
      2'd2:    return 7'h14;
      default: return 7'h54;
    endcase
  endfunction

  task automatic put_byte(input bit d, input logic [7:0] b);
    seq_data[seq_len] = d;
    seq_byte[seq_len] = b;
    seq_len++;
  endtask

  task automatic goto_cell(input int col, input int row);
    logic [6:0] addr;
    if (col >= COLUMNS) col = 0;
    if (row >= ROWS) row = 0;
    term_col = col[4:0];
    term_row = row[1:0];
    addr = 7'(col) + row_base(term_row);
    put_byte(1'b0, clt_pkg::LcdSetAddr | {1'b0, addr});
  endtask

  task automatic blank_next_row();
    goto_cell(0, term_row + 1);
    repeat (COLUMNS) put_byte(1'b1, clt_pkg::LcdSpace);
    goto_cell(term_col, term_row);
  endtask

  task automatic predict_lcd_bytes(input logic [7:0] c);
    int step;
    int col;
    lcd_word_t w;
    seq_len = 0;
    case (c)
      clt_pkg::ChrNewline:   blank_next_row();
      clt_pkg::ChrBackspace: goto_cell((term_col == 0) ? 0 : term_col - 1, term_row);
      clt_pkg::ChrBell:      ;
      clt_pkg::ChrFormFeed: begin
        put_byte(1'b0, clt_pkg::LcdClear);
        term_col = '0;
        term_row = '0;
      end
      clt_pkg::ChrTab: begin
        step = (term_tab == 0) ? 1 : term_tab;
        col = term_col + step - (term_col % step);
        goto_cell(col, term_row + ((col >= COLUMNS) ? 1 : 0));
      end
      default: begin
        if (term_col >= COLUMNS) begin
          blank_next_row();
          n_wraps++;
        end
        term_col = term_col + 5'd1;
        put_byte(1'b1, c);
      end
    endcase
    for (int i = 0; i < seq_len; i++) begin
      w.is_data  = seq_data[i];
      w.lcd_byte = seq_byte[i];
      w.last     = (i == seq_len - 1);
      pending_lcd_q.push_back(w);
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    char_q.push_back(c);
    n_queued++;
  endtask

  task automatic queue_random(input int n);
    int k;
    int pick;
    int burst;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        burst = $urandom_range(15, 25);
        if (burst > n - k) burst = n - k;
        repeat (burst) send_char(8'($urandom_range(32, 126)));
        k += burst;
      end else if (pick < 40) begin
        send_char(8'($urandom_range(32, 126)));
        k++;
      end else if (pick < 60) begin
        send_char(8'($urandom_range(0, 255)));
        k++;
      end else if (pick < 70) begin
        send_char(clt_pkg::ChrNewline);
        k++;
      end else if (pick < 80) begin
        send_char(clt_pkg::ChrTab);
        k++;
      end else if (pick < 88) begin
        send_char(clt_pkg::ChrBackspace);
        k++;
      end else if (pick < 93) begin
        send_char(clt_pkg::ChrFormFeed);
        k++;
      end else begin
        send_char(clt_pkg::ChrBell);
        k++;
      end
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || pending_lcd_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_tab_step(input logic [4:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    term_tab = v;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // input side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_lcd_bytes(s_axis_tdata);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= char_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side ready, with a long hold on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_bytes++;
      if (pending_lcd_q.size() == 0) begin
        $error("unexpected LCD byte: lcd_byte %h is_data %b last %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        n_err++;
      end else begin
        got_word = pending_lcd_q.pop_front();
        if (m_axis_tuser !== got_word.is_data) begin
          $error("is_data: expected %b, got %b", got_word.is_data, m_axis_tuser);
          n_err++;
        end
        if (m_axis_tdata !== got_word.lcd_byte) begin
          $error("lcd_byte: expected %h, got %h", got_word.lcd_byte, m_axis_tdata);
          n_err++;
        end
        if (m_axis_tlast !== got_word.last) begin
          $error("last: expected %b, got %b", got_word.last, m_axis_tlast);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    term_col = '0;
    term_row = '0;
    term_tab = clt_pkg::TabStepReset;
    set_idling(13, 69);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_char(directed[i]);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 1) set_idling(69, 13);
      if (ph == 3) set_idling(0, 0);
      set_tab_step(tab_plan[ph]);
      if (ph == 1) hold_req = 1'b1;
      queue_random(ITEMS_PER_STEP);
      wait_drained();
    end
    $display("summary: %0d characters, %0d LCD bytes checked, %0d wraps by printing",
             n_accepted, n_bytes, n_wraps);
    $display("summary: tab steps 4 0 31 1 20 7, three idle patterns, one long output stall");
    if (n_err == 0 && pending_lcd_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- char_lcd_terminal_controller.f -----
rtl/clt_pkg.sv
rtl/char_lcd_terminal_controller.sv
tb/tb_char_lcd_terminal_controller.sv
